// ===== design/facorr_pkg.sv =====
// ----------------------------------------------------------------------------
// Full autocorrelation package
// Shared widths, constants and the tag carried alongside the multiply-
// accumulate pipeline.
// ----------------------------------------------------------------------------
package facorr_pkg;

    localparam int CFG_W  = 5;
    localparam int POS_W  = 5;
    localparam int CORR_W = 20;
    localparam int OUT_W  = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [CORR_W-1:0] CORR_MAX  = 20'hFFFFF;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_tag_t;

endpackage

// ===== design/full_autocorrelation_top.sv =====
// ----------------------------------------------------------------------------
// Full autocorrelation top level
// Loads a record of N samples, then streams the 2N-1 autocorrelation values.
//
//  Channel  Signals                   Contents
//  -------  ------------------------  ----------------------------------------
//  s_       tvalid tready tdata       tdata: sample
//  m_       tvalid tready tdata tlast tdata: position, corr_value; tlast: is_last
//  cfg_     wr_en wr_data             sample_count
//
//  Load: one sample per cycle while tready is high.
//  Sums: one product per cycle through the shared MAC, N(N+1)/2 per record.
//  Output: a new sum store read waits until the previous one is registered.
//  s_tready is low from the last sample of a record until its last result is
//  registered; a stalled sink holds the output register and the sequencer.
//  Reset leaves sample_count at 16 and the record empty.
// ----------------------------------------------------------------------------
module full_autocorrelation_top
    import facorr_pkg::*;
#(
    parameter int MAX_SAMPLES = 16,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_W-1:0]                    m_tdata,   // [4:0] position, [24:5] corr_value
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [CFG_W-1:0]                    cfg_wr_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = $clog2(2 * MAX_SAMPLES);

    localparam logic [1:0] ST_LOAD      = 2'd0;
    localparam logic [1:0] ST_MAC_ISSUE = 2'd1;
    localparam logic [1:0] ST_MAC_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT      = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CFG_W-1:0]       cfg_count_reg;
    logic [AW-1:0]          loaded_reg, loaded_next;
    logic [AW-1:0]          i_reg, i_next;
    logic [AW-1:0]          y_reg, y_next;
    logic [AW-1:0]          wr_idx_reg, wr_idx_next;
    logic [PW-1:0]          p_reg, p_next;
    logic                   p_done_reg, p_done_next;
    logic                   pend_reg;
    logic                   pend_last_reg;
    logic [POS_W-1:0]       pend_pos_reg;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_last_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic [CORR_W-1:0]      out_corr_reg;
    mac_tag_t               tag0, tag1_reg;

    logic [CW-1:0]          n_eff;
    logic [AW-1:0]          nm1;
    logic [PW-1:0]          pos_last;
    logic                   s_accept;
    logic                   mac_issue;
    logic                   emit_issue;
    logic [AW-1:0]          addr_b;
    logic [AW-1:0]          half_rd_addr;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   sum_valid;
    logic [CORR_W-1:0]      sum;
    logic [CORR_W-1:0]      half_rd_data;

    always_comb
    begin
        if (cfg_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(cfg_count_reg) > MAX_SAMPLES)
        begin
            n_eff = CW'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = CW'(cfg_count_reg);
        end
    end

    assign nm1        = AW'(n_eff - CW'(1));
    assign pos_last   = PW'({nm1, 1'b0});
    assign s_tready   = (state_reg == ST_LOAD);
    assign s_accept   = s_tvalid && s_tready;
    assign mac_issue  = (state_reg == ST_MAC_ISSUE);
    assign emit_issue = (state_reg == ST_EMIT) && !p_done_reg && !pend_reg
                        && (!out_valid_reg || m_tready);
    assign addr_b     = y_reg + (nm1 - i_reg);
    assign half_rd_addr = (p_reg <= PW'(nm1)) ? p_reg[AW-1:0] : AW'(pos_last - p_reg);

    always_comb
    begin
        tag0.valid = mac_issue;
        tag0.first = (y_reg == '0);
        tag0.last  = (y_reg == i_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        i_next         = i_reg;
        y_next         = y_reg;
        wr_idx_next    = wr_idx_reg;
        p_next         = p_reg;
        p_done_next    = p_done_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end

        if (sum_valid)
        begin
            wr_idx_next = wr_idx_reg + AW'(1);
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (loaded_reg == nm1)
                    begin
                        loaded_next = '0;
                        i_next      = '0;
                        y_next      = '0;
                        state_next  = ST_MAC_ISSUE;
                    end
                    else
                    begin
                        loaded_next = loaded_reg + AW'(1);
                    end
                end
            end
            ST_MAC_ISSUE:
            begin
                if (y_reg == i_reg)
                begin
                    y_next = '0;
                    if (i_reg == nm1)
                    begin
                        i_next     = '0;
                        state_next = ST_MAC_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + AW'(1);
                    end
                end
                else
                begin
                    y_next = y_reg + AW'(1);
                end
            end
            ST_MAC_DRAIN:
            begin
                if (sum_valid && (wr_idx_reg == nm1))
                begin
                    wr_idx_next = '0;
                    p_next      = '0;
                    p_done_next = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_issue)
                begin
                    p_next = p_reg + PW'(1);
                    if (p_reg == pos_last)
                    begin
                        p_done_next = 1'b1;
                    end
                end
                if (pend_reg && pend_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_wr_en)
        begin
            loaded_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cfg_count_reg <= CFG_RESET;
            loaded_reg    <= '0;
            i_reg         <= '0;
            y_reg         <= '0;
            wr_idx_reg    <= '0;
            p_reg         <= '0;
            p_done_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            tag1_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            i_reg         <= i_next;
            y_reg         <= y_next;
            wr_idx_reg    <= wr_idx_next;
            p_reg         <= p_next;
            p_done_reg    <= p_done_next;
            pend_reg      <= emit_issue;
            out_valid_reg <= out_valid_next;
            tag1_reg      <= tag0;
            if (cfg_wr_en)
            begin
                cfg_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_issue)
        begin
            pend_pos_reg  <= POS_W'(p_reg);
            pend_last_reg <= (p_reg == pos_last);
        end
        if (pend_reg)
        begin
            out_pos_reg  <= pend_pos_reg;
            out_last_reg <= pend_last_reg;
            out_corr_reg <= half_rd_data;
        end
    end

    facorr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (s_accept),
        .wr_addr (loaded_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (mac_issue),
        .rd_addr (y_reg),
        .rd_data (sample_a)
    );

    facorr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (s_accept),
        .wr_addr (loaded_reg),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (mac_issue),
        .rd_addr (addr_b),
        .rd_data (sample_b)
    );

    facorr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag1_reg),
        .op_a      (sample_a),
        .op_b      (sample_b),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    facorr_ram #(
        .WIDTH (CORR_W),
        .DEPTH (MAX_SAMPLES)
    ) u_half (
        .clk     (clk),
        .wr_en   (sum_valid),
        .wr_addr (wr_idx_reg),
        .wr_data (sum),
        .rd_en   (emit_issue),
        .rd_addr (half_rd_addr),
        .rd_data (half_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_corr_reg, out_pos_reg});

    a_sum_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> (state_reg == ST_MAC_ISSUE || state_reg == ST_MAC_DRAIN))
        else $error("sum completed outside the accumulate phase");

    a_sum_index: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid |-> (wr_idx_reg <= nm1))
        else $error("sum store index beyond record length");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_EMIT))
        else $error("result read pending outside the output phase");

    a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (!out_valid_reg || m_tready))
        else $error("result read would overwrite an unconsumed result");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pend_last_reg) |=> (state_reg == ST_LOAD) && m_tvalid && m_tlast)
        else $error("final result did not close the record");

endmodule

// ===== design/facorr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module facorr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/facorr_mac.sv =====
// ----------------------------------------------------------------------------
// Full autocorrelation multiply-accumulate unit
// Registered product, then a saturating accumulate; a sum is reported on the
// last term of each lag.
// ----------------------------------------------------------------------------
module facorr_mac
    import facorr_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mac_tag_t               tag_in,
    input  logic [SAMPLE_BITS-1:0] op_a,
    input  logic [SAMPLE_BITS-1:0] op_b,
    output logic                   sum_valid,
    output logic [CORR_W-1:0]      sum
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = ((PROD_W > CORR_W) ? PROD_W : CORR_W) + 1;

    mac_tag_t           tag_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CORR_W-1:0]  acc_reg;
    logic [CORR_W-1:0]  acc_base;
    logic [SUM_W-1:0]   sum_wide;
    logic [CORR_W-1:0]  acc_next;

    always_comb
    begin
        acc_base = tag_reg.first ? '0 : acc_reg;
        sum_wide = SUM_W'(acc_base) + SUM_W'(prod_reg);
        acc_next = (sum_wide > SUM_W'(CORR_MAX)) ? CORR_MAX : sum_wide[CORR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum_valid = tag_reg.valid && tag_reg.last;
    assign sum       = acc_next;

endmodule
